>>> sv/tspq_pkg.sv
// ---------------------------------------------------------------------------
// tspq_pkg: shared constants
// Constants, register indexes and the CORDIC angle table for the
// three-step phase wrap quality block.
// ---------------------------------------------------------------------------
package tspq_pkg;

    localparam int SUM_W     = 10;
    localparam int RANGE_W   = 10;
    localparam int ROW_W     = 12;
    localparam int QUAL_W    = 19;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;

    localparam int CORDIC_STEPS = 28;
    localparam int STEP_W       = 5;
    localparam int CORD_W       = 31;
    localparam int ANG_W        = 34;

    localparam logic signed [17:0] SQRT3_Q16   = 18'sd113512;
    localparam logic [17:0]        NORM_SCALE  = 18'd195840;
    localparam logic [RANGE_W-1:0] RANGE_FULL  = 10'd765;
    localparam logic [QUAL_W-1:0]  QUALITY_MAX = 19'h7FFFF;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_THRESH = 2'd2;

    function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [31:0] a;
        unique case (i)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            5'd24: a = 32'h00000029;
            5'd25: a = 32'h00000014;
            5'd26: a = 32'h0000000A;
            5'd27: a = 32'h00000005;
            default: a = 32'h0;
        endcase
        return a;
    endfunction

endpackage

>>> sv/tspq_ram.sv
// ---------------------------------------------------------------------------
// tspq_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module tspq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/three_step_phase_wrap_quality.sv
// ---------------------------------------------------------------------------
// three_step_phase_wrap_quality: wrapped phase and quality from three captures
// Raster-order RGB pixels of three phase-shifted captures in; per pixel the
// wrapped phase, noise flag and quality figure out, one row behind.
// ---------------------------------------------------------------------------
// One pixel word is processed at a time. A word yields no result, one
// result or two (last row), and each result may wait on m_ready. A word
// passes through setup, 28 iterations of the shared CORDIC vectoring unit,
// and one pass of the bit-serial divider for each result. The line stores
// are read during the CORDIC iterations on a single read port. The next
// word is taken while the final result still waits on m_valid.
module three_step_phase_wrap_quality #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PHASE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_red_a,
    input  logic [7:0]  s_green_a,
    input  logic [7:0]  s_blue_a,
    input  logic [7:0]  s_red_b,
    input  logic [7:0]  s_green_b,
    input  logic [7:0]  s_blue_b,
    input  logic [7:0]  s_red_c,
    input  logic [7:0]  s_green_c,
    input  logic [7:0]  s_blue_c,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [9:0]  m_pixel_col,
    output logic [11:0] m_pixel_row,
    output logic        m_noisy,
    output logic signed [15:0] m_wrapped_phase,
    output logic [18:0] m_quality,
    output logic        m_last_of_item,
    output logic        m_end_of_frame,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [tspq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tspq_pkg::CFG_DAT_W-1:0] cfg_data
);

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int WW   = XW + 1;
    localparam int PB   = PHASE_BITS;
    localparam int DW   = PB + 2;
    localparam int NW   = DW + 18;
    localparam int SH_R = (PB >= 16) ? PB - 16 : 0;
    localparam int SH_L = (PB < 16) ? 16 - PB : 0;
    localparam int CW   = tspq_pkg::CORD_W;
    localparam int ZW   = tspq_pkg::ANG_W;
    localparam int QW   = tspq_pkg::QUAL_W;
    localparam int RW   = tspq_pkg::RANGE_W;
    localparam logic [PB-1:0] HALF     = PB'(1) << (PB - 1);
    localparam logic [PB-1:0] QUARTER  = PB'(1) << (PB - 2);
    localparam logic [PB-1:0] NEG_QTR  = PB'(3) << (PB - 2);
    localparam logic signed [ZW-1:0] ROUND_ADD = ZW'(1) << (31 - PB);
    localparam logic [WW-1:0] W_MAX = WW'(MAX_WIDTH);
    localparam logic [WW-1:0] W_MIN = WW'(3);

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_ROT, S_CORD, S_ROUND, S_WRITE, S_MUL, S_SEL,
        S_DIV, S_EMIT_A, S_EMIT_B
    } state_t;

    state_t state_reg;

    // configuration
    logic [10:0] frame_width_reg;
    logic [11:0] frame_height_reg;
    logic [9:0]  noise_thresh_reg;

    // position
    logic [XW-1:0] col_count_reg;
    logic [11:0]   row_count_reg;
    logic [XW-1:0] x_reg;
    logic [11:0]   y_reg;
    logic [WW-1:0] w_reg;
    logic          last_row_reg;

    // pixel
    logic [9:0]  sa_reg, sb_reg, sc_reg;
    logic [RW-1:0] r_reg;
    logic        noisy_reg;
    logic signed [CW-1:0] xraw_reg, yraw_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0] cz_reg;
    logic [tspq_pkg::STEP_W-1:0] step_reg;
    logic [PB-1:0] p_reg;

    // line store reads
    logic [PB-1:0] pp_reg, pl_reg, pr_reg, pu_reg;
    logic [RW-1:0] prange_reg;
    logic          pnoise_reg;
    logic [DW-1:0] dsum_reg;
    logic          interior_reg;
    logic [NW-1:0] prod_reg;

    // divider
    logic [QW-1:0] num_reg;
    logic [RW-1:0] den_reg;
    logic [RW:0]   rem_reg;
    logic [4:0]    dcnt_reg;
    logic          qmax_reg;
    logic          second_reg;

    // output
    logic          m_valid_reg;
    logic [9:0]    o_col_reg;
    logic [11:0]   o_row_reg;
    logic          o_noisy_reg;
    logic [15:0]   o_phase_reg;
    logic [QW-1:0] o_qual_reg;
    logic          o_last_reg;
    logic          o_eof_reg;

    // ------------------------------------------------------------------
    // input position and sums
    logic [WW-1:0] w_eff;
    logic [11:0]   h_eff;
    logic [XW-1:0] x_in;
    logic [12:0]   y_in;
    logic [11:0]   y_fix;
    logic [9:0]    sa_in, sb_in, sc_in;
    logic          s_acc;

    always_comb begin
        if (WW'(frame_width_reg) < W_MIN) begin
            w_eff = W_MIN;
        end else if (WW'(frame_width_reg) > W_MAX) begin
            w_eff = W_MAX;
        end else begin
            w_eff = WW'(frame_width_reg);
        end
        h_eff = (frame_height_reg == 12'd0) ? 12'd1 : frame_height_reg;
        if (WW'(col_count_reg) >= w_eff) begin
            x_in = '0;
            y_in = 13'(row_count_reg) + 13'd1;
        end else begin
            x_in = col_count_reg;
            y_in = 13'(row_count_reg);
        end
        y_fix = (y_in >= 13'(h_eff)) ? 12'd0 : y_in[11:0];
        sa_in = 10'(s_red_a) + 10'(s_green_a) + 10'(s_blue_a);
        sb_in = 10'(s_red_b) + 10'(s_green_b) + 10'(s_blue_b);
        sc_in = 10'(s_red_c) + 10'(s_green_c) + 10'(s_blue_c);
    end

    assign s_acc     = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // setup arithmetic
    logic [9:0] mx, mn;
    logic signed [12:0] xd, yd;
    logic signed [29:0] ymul;

    always_comb begin
        mx = (sa_reg > sb_reg) ? sa_reg : sb_reg;
        if (sc_reg > mx) mx = sc_reg;
        mn = (sa_reg < sb_reg) ? sa_reg : sb_reg;
        if (sc_reg < mn) mn = sc_reg;
        xd = $signed({2'b0, sb_reg, 1'b0}) - $signed({3'b0, sa_reg})
           - $signed({3'b0, sc_reg});
        yd = $signed({3'b0, sa_reg}) - $signed({3'b0, sc_reg});
        ymul = 30'(yd * tspq_pkg::SQRT3_Q16);
    end

    // CORDIC step
    logic signed [CW-1:0] dxs, dys;
    logic signed [ZW-1:0] atan_s;
    logic signed [ZW-1:0] zrnd;

    always_comb begin
        dxs    = cx_reg >>> step_reg;
        dys    = cy_reg >>> step_reg;
        atan_s = $signed({2'b0, tspq_pkg::atan_turn(step_reg)});
        zrnd   = (cz_reg + ROUND_ADD) >>> (32 - PB);
    end

    // line store ports
    logic [XW:0]   ph_raddr, ph_waddr;
    logic [PB-1:0] ph_rdata;
    logic [RW:0]   rn_rdata;
    logic          ln_we;

    always_comb begin
        unique case (step_reg)
            5'd0:    ph_raddr = {~y_reg[0], x_reg};
            5'd1:    ph_raddr = {~y_reg[0], x_reg - XW'(1)};
            5'd2:    ph_raddr = {~y_reg[0], x_reg + XW'(1)};
            default: ph_raddr = {y_reg[0], x_reg};
        endcase
        ph_waddr = {y_reg[0], x_reg};
        ln_we    = (state_reg == S_WRITE);
    end

    tspq_ram #(.WIDTH(PB), .DEPTH(2 * MAX_WIDTH)) u_phase_ram (
        .aclk  (aclk),
        .we    (ln_we),
        .waddr (ph_waddr),
        .wdata (p_reg),
        .raddr (ph_raddr),
        .rdata (ph_rdata)
    );

    tspq_ram #(.WIDTH(RW + 1), .DEPTH(MAX_WIDTH)) u_range_ram (
        .aclk  (aclk),
        .we    (ln_we),
        .waddr (x_reg),
        .wdata ({noisy_reg, r_reg}),
        .raddr (x_reg),
        .rdata (rn_rdata)
    );

    // wrapped distance
    function automatic logic [PB-1:0] wdist(input logic [PB-1:0] a, input logic [PB-1:0] b);
        logic [PB-1:0] d;
        d = a - b;
        return (d > HALF) ? (PB'(0) - d) : d;
    endfunction

    function automatic logic [15:0] phase16(input logic [PB-1:0] p);
        logic [23:0] pe;
        pe = 24'(p);
        if (PB >= 16) return 16'(pe >> SH_R);
        return 16'(pe << SH_L);
    endfunction

    // divider step
    logic [RW:0]   rem_sh;
    logic          qbit;
    logic [RW:0]   rem_nx;

    always_comb begin
        rem_sh = {rem_reg[RW-1:0], num_reg[QW-1]};
        qbit   = (rem_sh >= {1'b0, den_reg});
        rem_nx = qbit ? (rem_sh - {1'b0, den_reg}) : rem_sh;
    end

    logic out_free;
    logic emit_go;
    assign out_free = !m_valid_reg || m_ready;
    assign emit_go  = ((state_reg == S_EMIT_A) || (state_reg == S_EMIT_B)) && out_free;

    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            frame_width_reg  <= 11'd640;
            frame_height_reg <= 12'd480;
            noise_thresh_reg <= 10'd38;
            col_count_reg    <= '0;
            row_count_reg    <= '0;
            m_valid_reg      <= 1'b0;
            step_reg         <= '0;
            dcnt_reg         <= '0;
            second_reg       <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    tspq_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[10:0];
                    tspq_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                    tspq_pkg::REG_NOISE_THRESH: noise_thresh_reg <= cfg_data[9:0];
                    default: ;
                endcase
            end
            if (emit_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        sa_reg       <= sa_in;
                        sb_reg       <= sb_in;
                        sc_reg       <= sc_in;
                        x_reg        <= x_in;
                        y_reg        <= y_fix;
                        w_reg        <= w_eff;
                        last_row_reg <= (y_fix == h_eff - 12'd1);
                        second_reg   <= 1'b0;
                        if (WW'(x_in) + WW'(1) >= w_eff) begin
                            col_count_reg <= '0;
                            row_count_reg <= (13'(y_fix) + 13'd1 >= 13'(h_eff)) ?
                                             12'd0 : y_fix + 12'd1;
                        end else begin
                            col_count_reg <= x_in + XW'(1);
                            row_count_reg <= y_fix;
                        end
                        state_reg <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_reg     <= mx - mn;
                    noisy_reg <= ((mx - mn) <= noise_thresh_reg);
                    xraw_reg  <= CW'($signed({xd, 16'b0}));
                    yraw_reg  <= CW'(ymul);
                    state_reg <= S_ROT;
                end
                S_ROT: begin
                    if (xraw_reg < 0) begin
                        if (yraw_reg > 0) begin
                            cx_reg <= yraw_reg;
                            cy_reg <= -xraw_reg;
                            cz_reg <= ZW'(32'sh40000000);
                        end else begin
                            cx_reg <= -yraw_reg;
                            cy_reg <= xraw_reg;
                            cz_reg <= -ZW'(32'sh40000000);
                        end
                    end else begin
                        cx_reg <= xraw_reg;
                        cy_reg <= yraw_reg;
                        cz_reg <= '0;
                    end
                    step_reg  <= '0;
                    state_reg <= S_CORD;
                end
                S_CORD: begin
                    if (!cy_reg[CW-1]) begin
                        cx_reg <= cx_reg + dys;
                        cy_reg <= cy_reg - dxs;
                        cz_reg <= cz_reg + atan_s;
                    end else begin
                        cx_reg <= cx_reg - dys;
                        cy_reg <= cy_reg + dxs;
                        cz_reg <= cz_reg - atan_s;
                    end
                    unique case (step_reg)
                        5'd1: begin
                            pp_reg     <= ph_rdata;
                            prange_reg <= rn_rdata[RW-1:0];
                            pnoise_reg <= rn_rdata[RW];
                        end
                        5'd2: pl_reg <= ph_rdata;
                        5'd3: pr_reg <= ph_rdata;
                        5'd4: pu_reg <= ph_rdata;
                        default: ;
                    endcase
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(tspq_pkg::CORDIC_STEPS - 1)) begin
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    priority if (yraw_reg == 0) begin
                        p_reg <= (xraw_reg < 0) ? HALF : '0;
                    end else if (xraw_reg == 0) begin
                        p_reg <= (yraw_reg > 0) ? QUARTER : NEG_QTR;
                    end else begin
                        p_reg <= zrnd[PB-1:0];
                    end
                    state_reg <= S_WRITE;
                end
                S_WRITE: begin
                    dsum_reg <= DW'(wdist(pp_reg, pl_reg)) + DW'(wdist(pp_reg, pr_reg))
                              + DW'(wdist(pp_reg, pu_reg)) + DW'(wdist(pp_reg, p_reg));
                    interior_reg <= !pnoise_reg && (y_reg >= 12'd2) && (x_reg != '0)
                                 && (WW'(x_reg) + WW'(1) < w_reg);
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    prod_reg  <= NW'(dsum_reg) * NW'(tspq_pkg::NORM_SCALE);
                    state_reg <= S_SEL;
                end
                S_SEL: begin
                    rem_reg  <= '0;
                    dcnt_reg <= '0;
                    priority if (y_reg != 12'd0) begin
                        if (interior_reg) begin
                            num_reg  <= QW'(prod_reg >> PB);
                            den_reg  <= prange_reg;
                            qmax_reg <= (prange_reg == '0);
                        end else begin
                            num_reg  <= QW'({prange_reg, 8'b0});
                            den_reg  <= tspq_pkg::RANGE_FULL;
                            qmax_reg <= 1'b0;
                        end
                        state_reg <= S_DIV;
                    end else if (last_row_reg) begin
                        num_reg    <= QW'({r_reg, 8'b0});
                        den_reg    <= tspq_pkg::RANGE_FULL;
                        qmax_reg   <= 1'b0;
                        second_reg <= 1'b1;
                        state_reg  <= S_DIV;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_DIV: begin
                    rem_reg  <= rem_nx;
                    num_reg  <= {num_reg[QW-2:0], qbit};
                    dcnt_reg <= dcnt_reg + 5'd1;
                    if (dcnt_reg == 5'(QW - 1)) begin
                        state_reg <= second_reg ? S_EMIT_B : S_EMIT_A;
                    end
                end
                S_EMIT_A: begin
                    if (out_free) begin
                        o_col_reg   <= 10'(x_reg);
                        o_row_reg   <= y_reg - 12'd1;
                        o_noisy_reg <= pnoise_reg;
                        o_phase_reg <= phase16(pp_reg);
                        o_qual_reg  <= qmax_reg ? tspq_pkg::QUALITY_MAX : num_reg;
                        o_last_reg  <= !last_row_reg;
                        o_eof_reg   <= 1'b0;
                        if (last_row_reg) begin
                            num_reg    <= QW'({r_reg, 8'b0});
                            den_reg    <= tspq_pkg::RANGE_FULL;
                            qmax_reg   <= 1'b0;
                            rem_reg    <= '0;
                            dcnt_reg   <= '0;
                            second_reg <= 1'b1;
                            state_reg  <= S_DIV;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_EMIT_B: begin
                    if (out_free) begin
                        o_col_reg   <= 10'(x_reg);
                        o_row_reg   <= y_reg;
                        o_noisy_reg <= noisy_reg;
                        o_phase_reg <= phase16(p_reg);
                        o_qual_reg  <= num_reg;
                        o_last_reg  <= 1'b1;
                        o_eof_reg   <= (WW'(x_reg) + WW'(1) == w_reg);
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pixel_col     = o_col_reg;
    assign m_pixel_row     = o_row_reg;
    assign m_noisy         = o_noisy_reg;
    assign m_wrapped_phase = $signed(o_phase_reg);
    assign m_quality       = o_qual_reg;
    assign m_last_of_item  = o_last_reg;
    assign m_end_of_frame  = o_eof_reg;

    // ------------------------------------------------------------------
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while one is in flight");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV && den_reg != '0 |-> rem_reg < {1'b0, den_reg})
        else $error("divider remainder out of range");

    a_eof_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_frame |-> m_last_of_item)
        else $error("end of frame on a non-final result");

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CORD |-> step_reg < 5'(tspq_pkg::CORDIC_STEPS))
        else $error("CORDIC step counter overrun");

endmodule

>>> sim/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking bench for three_step_phase_wrap_quality
// Drives raster pixel words of three captures with random bursts and gaps,
// stalls the result side on its own pattern, and checks every result word
// against an in-bench model of phase, range, noise and quality.
// ---------------------------------------------------------------------------
module testbench;

    localparam int MAXW     = 1024;
    localparam int PB       = 16;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [7:0] ra, ga, ba, rb, gb, bb, rc, gc, bc;
    } pixel_t;

    typedef struct packed {
        logic [9:0]         col;
        logic [11:0]        row;
        logic               noisy;
        logic signed [15:0] phase;
        logic [18:0]        qual;
        logic               last;
        logic               eof;
    } result_t;

    // directed row: pixel and, where obvious, the own-pixel result quality, noise flag and phase
    typedef struct {
        pixel_t     px;
        bit         known;
        logic [18:0] qual;
        logic        noisy;
        logic [15:0] phase;
    } dir_row_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    pixel_t s_px = '0;
    logic m_valid;
    logic m_ready = 0;
    result_t m_res;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [tspq_pkg::CFG_IDX_W-1:0] cfg_index = tspq_pkg::REG_FRAME_WIDTH;
    logic [tspq_pkg::CFG_DAT_W-1:0] cfg_data = '0;

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    three_step_phase_wrap_quality i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_red_a(s_px.ra), .s_green_a(s_px.ga), .s_blue_a(s_px.ba),
        .s_red_b(s_px.rb), .s_green_b(s_px.gb), .s_blue_b(s_px.bb),
        .s_red_c(s_px.rc), .s_green_c(s_px.gc), .s_blue_c(s_px.bc),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pixel_col(m_res.col), .m_pixel_row(m_res.row), .m_noisy(m_res.noisy),
        .m_wrapped_phase(m_res.phase), .m_quality(m_res.qual),
        .m_last_of_item(m_res.last), .m_end_of_frame(m_res.eof),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // model state
    int unsigned frm_w, frm_h, noise_th, col_n, row_n;
    logic [PB-1:0] phase_mem [2*MAXW];
    int unsigned   range_mem [MAXW];
    bit            noise_mem [MAXW];

    result_t expected_q[$];
    int errors = 0, mismatches = 0, results_seen = 0, words_sent = 0;
    int idle_cycles = 0;
    bit hold_off = 0;

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [PB-1:0] phase_calc(int sa, int sb, int sc);
        longint x, y, z, t, dx, dy, r;
        logic [31:0] tbl[28] = '{
            32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
            32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
            32'h00000014, 32'h0000000A, 32'h00000005};
        x = longint'(2*sb - sa - sc) * 65536;
        y = longint'(sa - sc) * 113512;
        z = 0;
        if (y == 0) return (x >= 0) ? '0 : PB'(1 << (PB-1));
        if (x == 0) return (y > 0) ? PB'(1 << (PB-2)) : PB'((1 << PB) - (1 << (PB-2)));
        if (x < 0) begin
            t = x;
            if (y > 0) begin x = y; y = -t; z = 64'h40000000; end
            else begin x = -y; y = t; z = -64'h40000000; end
        end
        for (int i = 0; i < 28; i++) begin
            dx = shr(x, i);
            dy = shr(y, i);
            if (y >= 0) begin x += dy; y -= dx; z += tbl[i]; end
            else begin x -= dy; y += dx; z -= tbl[i]; end
        end
        r = shr(z + (64'sd1 <<< (31-PB)), 32-PB);
        return r[PB-1:0];
    endfunction

    function automatic int unsigned wrap_gap(logic [PB-1:0] a, logic [PB-1:0] b);
        logic [PB-1:0] d;
        d = a - b;
        return (d > (1 << (PB-1))) ? (1 << PB) - d : d;
    endfunction

    function automatic logic [18:0] range_scaled(int unsigned r);
        return 19'((r * 256) / 765);
    endfunction

    task automatic predict_pixel(pixel_t p);
        int unsigned w, h, x, y, r, cur, prv, pr;
        int sa, sb, sc, mx, mn;
        bit nz, pn, last_row;
        logic [PB-1:0] ph, pp;
        longint unsigned d, v;
        result_t e;
        w = frm_w < 3 ? 3 : (frm_w > MAXW ? MAXW : frm_w);
        h = frm_h == 0 ? 1 : frm_h;
        x = col_n;
        y = row_n;
        if (x >= w) begin x = 0; y++; end
        if (y >= h) y = 0;
        last_row = (y == h - 1);
        sa = p.ra + p.ga + p.ba;
        sb = p.rb + p.gb + p.bb;
        sc = p.rc + p.gc + p.bc;
        mx = sa > sb ? sa : sb; if (sc > mx) mx = sc;
        mn = sa < sb ? sa : sb; if (sc < mn) mn = sc;
        r = mx - mn;
        nz = r <= noise_th;
        ph = phase_calc(sa, sb, sc);
        cur = (y & 1) * MAXW;
        prv = ((y + 1) & 1) * MAXW;
        if (y >= 1) begin
            pr = range_mem[x];
            pn = noise_mem[x];
            pp = phase_mem[prv + x];
            e.col = 10'(x); e.row = 12'(y - 1); e.noisy = pn; e.phase = pp;
            e.last = !last_row; e.eof = 0;
            if (!pn && y >= 2 && x >= 1 && x + 1 < w) begin
                d = wrap_gap(pp, phase_mem[prv+x-1]) + wrap_gap(pp, phase_mem[prv+x+1])
                  + wrap_gap(pp, phase_mem[cur+x]) + wrap_gap(pp, ph);
                if (pr == 0) e.qual = tspq_pkg::QUALITY_MAX;
                else begin
                    v = (d * 765 * 256) / (longint'(pr) << PB);
                    e.qual = v > tspq_pkg::QUALITY_MAX ? tspq_pkg::QUALITY_MAX : v[18:0];
                end
            end else e.qual = range_scaled(pr);
            expected_q.push_back(e);
        end
        phase_mem[cur + x] = ph;
        range_mem[x] = r;
        noise_mem[x] = nz;
        if (last_row) begin
            e.col = 10'(x); e.row = 12'(y); e.noisy = nz; e.phase = ph;
            e.qual = range_scaled(r); e.last = 1; e.eof = (x == w - 1);
            expected_q.push_back(e);
        end
        if (x + 1 >= w) begin
            col_n = 0;
            row_n = (y + 1 >= h) ? 0 : y + 1;
        end else begin
            col_n = x + 1;
            row_n = y;
        end
    endtask

    task automatic send_pixel(pixel_t p);
        s_px <= p;
        s_valid <= 1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_pixel(p);
        words_sent++;
        @(negedge aclk);
        s_valid <= 0;
        @(negedge aclk);
    endtask

    task automatic send_burst(pixel_t p, bit keep);
        // keep valid high across back-to-back words
        s_px <= p;
        s_valid <= 1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_pixel(p);
        words_sent++;
        @(negedge aclk);
        if (!keep) begin
            s_valid <= 0;
            @(negedge aclk);
        end
    endtask

    task automatic write_reg(logic [tspq_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
        cfg_index <= idx;
        cfg_data <= tspq_pkg::CFG_DAT_W'(val);
        cfg_valid <= 1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            tspq_pkg::REG_FRAME_WIDTH:  frm_w = val & 12'h7FF;
            tspq_pkg::REG_FRAME_HEIGHT: frm_h = val & 12'hFFF;
            tspq_pkg::REG_NOISE_THRESH: noise_th = val & 12'h3FF;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 0;
        @(negedge aclk);
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    // new frame geometry and noise threshold, written after the model drains
    task automatic set_frame(int unsigned w, int unsigned h, int unsigned th);
        drain();
        write_reg(tspq_pkg::REG_FRAME_WIDTH, w);
        write_reg(tspq_pkg::REG_FRAME_HEIGHT, h);
        write_reg(tspq_pkg::REG_NOISE_THRESH, th);
    endtask

    function automatic pixel_t rand_pixel();
        pixel_t p;
        p = 72'({$urandom, $urandom, $urandom});
        case ($urandom_range(0, 5))
            0: p = '0;
            1: p = '1;
            2: begin p.rb = p.ra; p.gb = p.ga; p.bb = p.ba;
                     p.rc = p.ra; p.gc = p.ga; p.bc = p.ba; end
            3: begin p.rc = p.ra; p.gc = p.ga; p.bc = p.ba; end
            default: ;
        endcase
        return p;
    endfunction

    // send w*h*n pixel words in random bursts; whole frames when w and h match the geometry
    task automatic send_frames(int unsigned w, int unsigned h, int n);
        int k, burst;
        burst = 0;
        for (k = 0; k < w * h * n; k++) begin
            if (burst == 0) begin
                repeat ($urandom_range(0, 1) ? $urandom_range(1, 30) : 0) @(negedge aclk);
                burst = $urandom_range(1, 12);
            end
            burst--;
            send_burst(rand_pixel(), burst != 0 && k + 1 < w * h * n);
        end
        s_valid <= 0;
    endtask

    // result side
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            result_t e;
            results_seen++;
            if (expected_q.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected result word %p", m_res);
            end else begin
                e = expected_q.pop_front();
                if (m_res !== e) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch: expected %p actual %p", e, m_res);
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_off) m_ready <= 0;
        else case (($urandom_range(0, 99) / 25))
            0: m_ready <= ($urandom_range(0, 3) != 0);
            1: m_ready <= 1;
            2: m_ready <= ($urandom_range(0, 1) != 0);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("timeout");
            $display("DONE: errors detected");
            $finish;
        end
    end

    dir_row_t dir_rows[];
    initial begin
        result_t e;
        frm_w = 640; frm_h = 480; noise_th = 38; col_n = 0; row_n = 0;
        foreach (range_mem[i]) begin range_mem[i] = 0; noise_mem[i] = 0; end
        foreach (phase_mem[i]) phase_mem[i] = 0;
        repeat (3) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // one-row frames: each word yields only its own result
        write_reg(tspq_pkg::REG_FRAME_WIDTH, 3);
        write_reg(tspq_pkg::REG_FRAME_HEIGHT, 0);
        write_reg(tspq_pkg::REG_NOISE_THRESH, 0);
        dir_rows = new[6];
        dir_rows[0] = '{'0, 1, 19'd0, 1'b1, 16'h0000};
        dir_rows[1] = '{'1, 1, 19'd0, 1'b1, 16'h0000};
        dir_rows[2] = '{{8'd255,8'd255,8'd0,8'd255,40'd0}, 1, 19'd170, 1'b0, 16'h4000};
        dir_rows[3] = '{{24'd0,8'd255,16'd0,8'd255,8'd255,8'd0},
                        1, 19'd170, 1'b0, 16'hC000};
        dir_rows[4] = '{{24'd0,8'd255,8'd255,8'd255,24'd0}, 1, 19'd256, 1'b0, 16'h0000};
        dir_rows[5] = '{{8'd255,8'd255,8'd255,24'd0,8'd255,8'd255,8'd255},
                        1, 19'd256, 1'b0, 16'h8000};
        foreach (dir_rows[i]) begin
            send_pixel(dir_rows[i].px);
            e = expected_q[$];
            if (dir_rows[i].known && (e.qual !== dir_rows[i].qual ||
                e.noisy !== dir_rows[i].noisy || e.phase !== dir_rows[i].phase)) begin
                errors++;
                $display("directed row %0d: table and model disagree", i);
            end
        end
        // small frame with interior pixels, max threshold, a 5x3 frame of random
        // words, then a partial row at saturated width
        set_frame(4, 4, 765);
        send_frames(4, 4, 1);
        set_frame(5, 3, 0);
        for (int i = 0; i < 15; i++)
            send_pixel(72'({$urandom_range(0, 1) ? 72'd0 : {9{8'hFF}}}
                           ^ {$urandom, $urandom, $urandom}));
        set_frame(2047, 1, 100);   // saturates to maximum width
        send_frames(200, 1, 1);
        set_frame(3, 1, 20);       // first word wraps the counters to the frame start
        send_frames(3, 1, 1);

        // random part
        set_frame(8, 6, 20);
        fork
            send_frames(8, 6, 4);
            begin
                repeat (50) @(negedge aclk);
                hold_off = 1;
                repeat (800) @(negedge aclk);
                hold_off = 0;
            end
        join
        set_frame(3, 7, 300);
        send_frames(3, 7, 3);
        set_frame(6, 4095, 5);
        send_frames(6, 2, 1);
        set_frame(6, 2, 5);        // next word wraps the counters to the frame start
        drain();
        set_frame(16, 5, 60);
        send_frames(16, 5, 2);
        drain();

        $display("sent %0d pixel words, checked %0d result words over several geometries",
                 words_sent, results_seen);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d errors, %0d results still expected", errors, expected_q.size());
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
